>>> hw/rtl/pvl_pkg.sv
// ----------------------------------------------------------------------------
// pvl_pkg
// Shared types and constants for the motor PI velocity loop
// ----------------------------------------------------------------------------
package pvl_pkg;

    localparam int DemandWidth   = 16;
    localparam int PosWidth      = 16;
    localparam int GainWidth     = 16;
    localparam int DriveWidth    = 8;
    localparam int SumWidth      = 32;
    localparam int ErrWidth      = DemandWidth + 1;
    localparam int PropProdWidth = GainWidth + ErrWidth;
    localparam int IntProdWidth  = GainWidth + SumWidth;
    localparam int CmdWidth      = IntProdWidth + 1;

    // divide by five as multiply by 2^18/5 rounded up, then shift
    localparam int          RecipShift = 18;
    localparam logic [16:0] DemandRecip = 17'd52429;

    localparam logic signed [DriveWidth-1:0] DriveMax = 8'sd100;
    localparam logic signed [DriveWidth-1:0] DriveMin = -8'sd100;

    typedef enum logic {
        OpSample = 1'b0,
        OpTick   = 1'b1
    } op_t;

    typedef enum logic {
        RegPropGain     = 1'b0,
        RegIntegralGain = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        op_t                           op;
        logic                          enc_a;
        logic signed [DemandWidth-1:0] target;
    } item_t;

    typedef struct packed {
        logic signed [GainWidth-1:0] prop;
        logic signed [GainWidth-1:0] integ;
    } gains_t;

endpackage

>>> hw/rtl/pvl_in_stage.sv
// ----------------------------------------------------------------------------
// pvl_in_stage
// Input register; scales the velocity demand by one fifth on the way in
// ----------------------------------------------------------------------------
module pvl_in_stage
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic                                  enc_a,
    input  logic signed [pvl_pkg::DemandWidth-1:0] demand,
    input  logic                                  fire,
    output logic                                  item_valid,
    output pvl_pkg::item_t                        item
);

    logic                                   valid_reg;
    logic                                   valid_next;
    pvl_pkg::item_t                         item_reg;
    logic                                   accept;
    logic                                   neg;
    logic [pvl_pkg::DemandWidth-1:0]        mag;
    logic [32:0]                            prod;
    logic [pvl_pkg::DemandWidth-1:0]        quot;
    logic signed [pvl_pkg::DemandWidth-1:0] target;

    assign in_stall = valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    // truncating divide by five on the magnitude
    always_comb
    begin
        neg    = demand[pvl_pkg::DemandWidth-1];
        mag    = neg ? (-demand) : demand;
        prod   = 33'(mag) * 33'(pvl_pkg::DemandRecip);
        quot   = pvl_pkg::DemandWidth'(prod >> pvl_pkg::RecipShift);
        target = neg ? -$signed(quot) : $signed(quot);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op     <= pvl_pkg::op_t'(op);
            item_reg.enc_a  <= enc_a;
            item_reg.target <= target;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hw/rtl/pvl_core.sv
// ----------------------------------------------------------------------------
// pvl_core
// Encoder counter, PI update and result registers
// ----------------------------------------------------------------------------
module pvl_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    input  pvl_pkg::item_t                         item,
    input  pvl_pkg::gains_t                        gains,
    output logic                                   fire,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pvl_pkg::DriveWidth-1:0]  drive_out,
    output logic signed [pvl_pkg::PosWidth-1:0]    speed,
    output logic signed [pvl_pkg::PosWidth-1:0]    count
);

    logic                                     out_valid_reg;
    logic                                     out_valid_next;
    logic [pvl_pkg::PosWidth-1:0]             position_reg;
    logic [pvl_pkg::PosWidth-1:0]             position_next;
    logic [pvl_pkg::PosWidth-1:0]             prev_pos_reg;
    logic [pvl_pkg::PosWidth-1:0]             prev_pos_next;
    logic [pvl_pkg::SumWidth-1:0]             sum_reg;
    logic [pvl_pkg::SumWidth-1:0]             sum_next;
    logic                                     last_a_reg;
    logic                                     last_a_next;
    logic signed [pvl_pkg::DriveWidth-1:0]    drive_reg;
    logic signed [pvl_pkg::DriveWidth-1:0]    drive_next;
    logic [pvl_pkg::PosWidth-1:0]             speed_reg;
    logic [pvl_pkg::PosWidth-1:0]             speed_next;

    logic [pvl_pkg::PosWidth-1:0]             spd;
    logic signed [pvl_pkg::ErrWidth-1:0]      err;
    logic [pvl_pkg::SumWidth-1:0]             sum_new;
    logic signed [pvl_pkg::PropProdWidth-1:0] p_prod;
    logic signed [pvl_pkg::IntProdWidth-1:0]  i_prod;
    logic signed [pvl_pkg::CmdWidth-1:0]      cmd;

    assign fire = item_valid && (!out_valid_reg || !out_stall);

    // pi arithmetic for a control tick
    always_comb
    begin
        spd     = position_reg - prev_pos_reg;
        err     = $signed({item.target[pvl_pkg::DemandWidth-1], item.target})
                - $signed({spd[pvl_pkg::PosWidth-1], spd});
        sum_new = sum_reg + pvl_pkg::SumWidth'(err);
        p_prod  = gains.prop * err;
        i_prod  = gains.integ * $signed(sum_new);
        cmd     = pvl_pkg::CmdWidth'(p_prod) + pvl_pkg::CmdWidth'(i_prod);
    end

    always_comb
    begin
        position_next  = position_reg;
        prev_pos_next  = prev_pos_reg;
        sum_next       = sum_reg;
        last_a_next    = last_a_reg;
        drive_next     = drive_reg;
        speed_next     = speed_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            case (item.op)
                pvl_pkg::OpSample:
                begin
                    last_a_next = item.enc_a;
                    if (item.enc_a != last_a_reg)
                    begin
                        if (drive_reg > 0)
                        begin
                            position_next = position_reg + 1'b1;
                        end
                        else if (drive_reg < 0)
                        begin
                            position_next = position_reg - 1'b1;
                        end
                    end
                end
                pvl_pkg::OpTick:
                begin
                    speed_next    = spd;
                    prev_pos_next = position_reg;
                    sum_next      = sum_new;
                    if (cmd > pvl_pkg::CmdWidth'(pvl_pkg::DriveMax))
                    begin
                        drive_next = pvl_pkg::DriveMax;
                    end
                    else if (cmd < pvl_pkg::CmdWidth'(pvl_pkg::DriveMin))
                    begin
                        drive_next = pvl_pkg::DriveMin;
                    end
                    else
                    begin
                        drive_next = pvl_pkg::DriveWidth'(cmd);
                    end
                end
                default:
                begin
                    last_a_next = last_a_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
            prev_pos_reg  <= '0;
            sum_reg       <= '0;
            last_a_reg    <= 1'b0;
            drive_reg     <= '0;
            speed_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            position_reg  <= position_next;
            prev_pos_reg  <= prev_pos_next;
            sum_reg       <= sum_next;
            last_a_reg    <= last_a_next;
            drive_reg     <= drive_next;
            speed_reg     <= speed_next;
        end
    end

    // state only moves when an item is taken, which a held result blocks, so it doubles as the result register
    assign out_valid = out_valid_reg;
    assign drive_out = drive_reg;
    assign speed     = $signed(speed_reg);
    assign count     = $signed(position_reg);

endmodule

>>> hw/rtl/motor_pi_velocity_loop.sv
// ----------------------------------------------------------------------------
// motor_pi_velocity_loop
// PI velocity loop with a single-channel encoder position counter
//
// channel   handshake             payload
// in        in_valid / in_stall   op, enc_a, demand
// out       out_valid / out_stall drive_out, speed, count
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle unless out_stall holds a result; result registered after the input transfer
// (input register, then one pass through the counter and pi arithmetic)
// out_stall holds the result; one further item waits in the input register
// cfg_ready always high; reset sets gains to 0 and 1, all but the item to zero
// ----------------------------------------------------------------------------
module motor_pi_velocity_loop
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   op,
    input  logic                                   enc_a,
    input  logic signed [pvl_pkg::DemandWidth-1:0] demand,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pvl_pkg::DriveWidth-1:0]  drive_out,
    output logic signed [pvl_pkg::PosWidth-1:0]    speed,
    output logic signed [pvl_pkg::PosWidth-1:0]    count,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_index,
    input  logic [pvl_pkg::GainWidth-1:0]          cfg_data
);

    pvl_pkg::gains_t gains_reg;
    pvl_pkg::gains_t gains_next;
    pvl_pkg::item_t  item;
    logic            item_valid;
    logic            fire;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (pvl_pkg::cfg_reg_t'(cfg_index))
                pvl_pkg::RegPropGain:     gains_next.prop  = $signed(cfg_data);
                pvl_pkg::RegIntegralGain: gains_next.integ = $signed(cfg_data);
                default:                  gains_next       = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.prop  <= '0;
            gains_reg.integ <= pvl_pkg::GainWidth'(1);
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    pvl_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .enc_a      (enc_a),
        .demand     (demand),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    pvl_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .gains      (gains_reg),
        .fire       (fire),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive_out  (drive_out),
        .speed      (speed),
        .count      (count)
    );

    // drive command stays inside its clip limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_out <= pvl_pkg::DriveMax && drive_out >= pvl_pkg::DriveMin))
    else $error("drive command outside clip range");

    // input side only stalls behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

    // a taken result with nothing queued leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !item_valid) |=> !out_valid)
    else $error("result repeated");

endmodule

>>> tb/tb_motor_pi_velocity_loop.sv
// ----------------------------------------------------------------------------
// tb_motor_pi_velocity_loop
// Self-checking bench for the PI velocity loop and its encoder counter
//
// A directed table runs first. It covers reset values, field extremes,
// direction changes of the count, a short sweep that carries the count up
// through zero, and gain extremes. Bursts of encoder samples closed by control
// ticks follow, under four mixes of sender gaps and receiver stalls, with new
// gains for each mix. Every result is compared with an in-bench prediction of
// the loop state, or with a value written into the table.
// ----------------------------------------------------------------------------
module tb_motor_pi_velocity_loop;

    import pvl_pkg::*;

    typedef struct packed {
        logic signed [DriveWidth-1:0] drive;
        logic signed [PosWidth-1:0]   speed;
        logic signed [PosWidth-1:0]   count;
    } loop_result_t;

    typedef enum logic [1:0] {
        RowSample,
        RowTick,
        RowSetProp,
        RowSetIntegral
    } row_kind_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic                          a;
        logic signed [DemandWidth-1:0] arg;
        int                            reps;
        bit                            lit;
        logic signed [DriveWidth-1:0]  w_drive;
        logic signed [PosWidth-1:0]    w_speed;
        logic signed [PosWidth-1:0]    w_count;
    } row_t;

    localparam int NumRows   = 30;
    localparam int PhaseLen  = 150;
    localparam int SweepLen  = 12;

    // a sample row with several reps toggles channel a on every rep
    localparam row_t PLAN [NumRows] = '{
        '{RowSample,      1'b0, 16'sh0000, 1, 1'b1,  8'sd0,    16'sd0,  16'sd0},
        '{RowSample,      1'b1, 16'sh7fff, 1, 1'b1,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b0, 16'sh7fff, 1, 1'b1,  8'sd100,  16'sd0,  16'sd0},
        '{RowSample,      1'b0, 16'sh8000, 1, 1'b1,  8'sd100,  16'sd0,  16'sd1},
        '{RowSample,      1'b0, 16'sh0000, 1, 1'b1,  8'sd100,  16'sd0,  16'sd1},
        '{RowTick,        1'b1, 16'sh8000, 1, 1'b1, -8'sd1,    16'sd1,  16'sd1},
        '{RowSample,      1'b1, 16'sh0000, 1, 1'b1, -8'sd1,    16'sd1,  16'sd0},
        '{RowSample,      1'b0, 16'sh0000, 1, 1'b1, -8'sd1,    16'sd1, -16'sd1},
        '{RowTick,        1'b0, 16'sh0000, 1, 1'b1,  8'sd1,   -16'sd2, -16'sd1},
        '{RowSample,      1'b1, 16'sh1234, SweepLen, 1'b0, 8'sd0, 16'sd0, 16'sd0},
        '{RowTick,        1'b0, 16'sh0000, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b1, 16'shffff, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b0, 16'shfffb, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b0, 16'sh0004, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSetProp,     1'b0, 16'sh7fff, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSetIntegral, 1'b0, 16'sh8000, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b0, 16'sh7fff, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSample,      1'b1, 16'sh8000, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSample,      1'b0, 16'sh7fff, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b1, 16'sh8000, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSetProp,     1'b0, 16'sh8000, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSetIntegral, 1'b0, 16'sh7fff, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b0, 16'sh7fff, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b0, 16'sh8000, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSetProp,     1'b0, 16'sh0003, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSetIntegral, 1'b0, 16'sh0000, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b0, 16'sh0007, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowTick,        1'b1, 16'shfff9, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSetIntegral, 1'b0, 16'sh0001, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0},
        '{RowSetProp,     1'b0, 16'sh0000, 1, 1'b0,  8'sd0,    16'sd0,  16'sd0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    op_t                           op = OpSample;
    logic                          enc_a = 1'b0;
    logic signed [DemandWidth-1:0] demand = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [DriveWidth-1:0]  drive_out;
    logic signed [PosWidth-1:0]    speed;
    logic signed [PosWidth-1:0]    count;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_index = 1'b0;
    logic [GainWidth-1:0]          cfg_data = '0;

    // predicted loop state
    logic signed [GainWidth-1:0]  kp = 16'sd0;
    logic signed [GainWidth-1:0]  ki = 16'sd1;
    logic [PosWidth-1:0]          pos_cnt = '0;
    logic [PosWidth-1:0]          pos_at_tick = '0;
    logic [SumWidth-1:0]          err_sum = '0;
    logic                         enc_last = 1'b0;
    logic signed [DriveWidth-1:0] drive_cmd = '0;
    logic [PosWidth-1:0]          speed_meas = '0;

    loop_result_t drive_speed_count_q[$];

    int send_gap_pct = 0;
    int stall_pct = 0;
    int n_items = 0;
    int n_random = 0;
    int n_checked = 0;
    int n_gain_writes = 0;
    int n_errors = 0;

    motor_pi_velocity_loop u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .enc_a     (enc_a),
        .demand    (demand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive_out (drive_out),
        .speed     (speed),
        .count     (count),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic loop_result_t step_velocity_loop(op_t op_sel, logic a_lvl,
                                                        logic signed [15:0] dem);
        int                          target;
        int                          err;
        longint                      cmd;
        logic signed [PosWidth-1:0]  spd;
        if (op_sel == OpSample)
        begin
            if (a_lvl != enc_last)
            begin
                if (drive_cmd > 0)
                    pos_cnt = pos_cnt + 1'b1;
                else if (drive_cmd < 0)
                    pos_cnt = pos_cnt - 1'b1;
                enc_last = a_lvl;
            end
        end
        else
        begin
            target = int'(dem) / 5;
            speed_meas = pos_cnt - pos_at_tick;
            pos_at_tick = pos_cnt;
            spd = speed_meas;
            err = target - int'(spd);
            err_sum = err_sum + 32'(err);
            cmd = longint'(kp) * longint'(err) + longint'(ki) * longint'($signed(err_sum));
            if (cmd > longint'(DriveMax))
                drive_cmd = DriveMax;
            else if (cmd < longint'(DriveMin))
                drive_cmd = DriveMin;
            else
                drive_cmd = 8'(cmd);
        end
        return '{drive_cmd, speed_meas, pos_cnt};
    endfunction

    task automatic send_item(op_t op_sel, logic a_lvl, logic signed [15:0] dem, bit lit,
                             loop_result_t want);
        loop_result_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= op_sel;
        enc_a <= a_lvl;
        demand <= dem;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = step_velocity_loop(op_sel, a_lvl, dem);
        drive_speed_count_q.push_back(lit ? want : predicted);
        n_items++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (drive_speed_count_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gain(cfg_reg_t sel, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (sel == RegPropGain)
            kp = value;
        else
            ki = value;
        n_gain_writes++;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(4))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_demand();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'(int'($urandom_range(600)) - 300);
        endcase
    endfunction

    // result check and receiver stalls
    always @(posedge clk)
    begin : check_results
        loop_result_t seen;
        loop_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{drive_out, speed, count};
            if (drive_speed_count_q.size() == 0)
            begin
                $error("result transfer with nothing expected: drive_out %0d speed %0d count %0d",
                       seen.drive, seen.speed, seen.count);
                n_errors++;
            end
            else
            begin
                want = drive_speed_count_q.pop_front();
                if (seen.drive !== want.drive)
                begin
                    $error("drive_out: expected %0d, got %0d", want.drive, seen.drive);
                    n_errors++;
                end
                if (seen.speed !== want.speed)
                begin
                    $error("speed: expected %0d, got %0d", want.speed, seen.speed);
                    n_errors++;
                end
                if (seen.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, seen.count);
                    n_errors++;
                end
                n_checked++;
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        int   gap_mix [4];
        int   stall_mix [4];
        int   in_phase;
        int   burst;
        logic enc_level;
        gap_mix = '{0, 62, 0, 31};
        stall_mix = '{0, 0, 62, 31};
        enc_level = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            case (PLAN[i].kind)
                RowSetProp:
                begin
                    wait_drained();
                    write_gain(RegPropGain, PLAN[i].arg);
                end
                RowSetIntegral:
                begin
                    wait_drained();
                    write_gain(RegIntegralGain, PLAN[i].arg);
                end
                default:
                begin
                    for (int r = 0; r < PLAN[i].reps; r++)
                        send_item(PLAN[i].kind == RowTick ? OpTick : OpSample,
                                  PLAN[i].a ^ r[0], PLAN[i].arg, PLAN[i].lit,
                                  '{PLAN[i].w_drive, PLAN[i].w_speed, PLAN[i].w_count});
                end
            endcase
        end

        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            write_gain(RegPropGain, pick_gain());
            write_gain(RegIntegralGain, pick_gain());
            send_gap_pct = gap_mix[p];
            stall_pct = stall_mix[p];
            in_phase = 0;
            while (in_phase < PhaseLen)
            begin
                burst = $urandom_range(12);
                repeat (burst)
                begin
                    if ($urandom_range(9) == 0)
                        send_item(op_t'($urandom_range(1)), 1'($urandom), 16'($urandom),
                                  1'b0, '0);
                    else
                    begin
                        if ($urandom_range(99) < 85)
                            enc_level = ~enc_level;
                        send_item(OpSample, enc_level, 16'($urandom), 1'b0, '0);
                    end
                end
                send_item(OpTick, 1'($urandom), pick_demand(), 1'b0, '0);
                in_phase += burst + 1;
            end
            n_random += in_phase;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("directed table of %0d rows, then %0d random transfers over 4 idling mixes",
                 NumRows, n_random);
        $display("%0d transfers in, %0d results checked, %0d gain writes, %0d mismatches",
                 n_items, n_checked, n_gain_writes, n_errors);
        if (n_errors == 0)
            $display("** motor_pi_velocity_loop: PASSED **");
        else
            $display("** motor_pi_velocity_loop: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still expected", drive_speed_count_q.size());
        $display("** motor_pi_velocity_loop: FAILED **");
        $finish;
    end

endmodule
